// ===== hw/rtl/stli_pkg.sv =====
`default_nettype none
package stli_pkg;
  localparam int TableDepth  = 4096;
  localparam int IndexWidth  = 12;
  localparam int CountWidth  = 13;
  localparam int ValueWidth  = 32;
  localparam int WeightWidth = 16;

  // Value store port select
  typedef enum logic [1:0] {
    RD_LO   = 2'd0,
    RD_LAST = 2'd1,
    RD_MID  = 2'd2,
    RD_HI   = 2'd3
  } rd_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load_query;
    logic    mem_write;
    logic    mem_read;
    rd_sel_t rd_sel;
    logic    cap_first;
    logic    cap_last;
    logic    step_search;
    logic    cap_lo;
    logic    cap_hi;
    logic    div_start;
    logic    mul_lo;
    logic    mul_hi;
    logic    sum_out;
    logic    set_clamp_first;
    logic    set_clamp_last;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic below_first;
    logic above_last;
    logic search_done;
    logic div_done;
  } dp_status_t;

  // Offset-binary form makes signed order unsigned order
  function automatic logic [ValueWidth-1:0] to_offset(input logic [ValueWidth-1:0] v);
    to_offset = {~v[ValueWidth-1], v[ValueWidth-2:0]};
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/stli_divider.sv =====
`default_nettype none
// Restoring divider: quotient = (num << 16) / den, one bit per cycle,
// clamped to 16 bits.
module stli_divider (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [stli_pkg::ValueWidth-1:0]  num,
  input  wire logic [stli_pkg::ValueWidth-1:0]  den,
  output logic                                  done,
  output logic [stli_pkg::WeightWidth-1:0]      quotient
);
  import stli_pkg::*;
  localparam int DivBits = ValueWidth + WeightWidth;
  localparam int StepW   = $clog2(DivBits + 1);

  logic [DivBits-1:0]    dividend;
  logic [ValueWidth:0]   rem;
  logic [ValueWidth-1:0] divisor;
  logic [StepW-1:0]      steps;
  logic                  busy;
  logic [ValueWidth:0]   trial;
  logic [ValueWidth:0]   shifted;

  assign shifted = {rem[ValueWidth-1:0], dividend[DivBits-1]};
  assign trial   = shifted - {1'b0, divisor};

  // Quotient bits collect in the low end of the dividend register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= StepW'(DivBits);
        dividend <= {num, {WeightWidth{1'b0}}};
        divisor  <= den;
        rem      <= '0;
      end else if (busy) begin
        if (!trial[ValueWidth]) begin
          rem      <= trial;
          dividend <= {dividend[DivBits-2:0], 1'b1};
        end else begin
          rem      <= shifted;
          dividend <= {dividend[DivBits-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Saturate to the largest Q0.16 weight
  assign quotient = (|dividend[DivBits-1:WeightWidth]) ? '1 : dividend[WeightWidth-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/stli_datapath.sv =====
`default_nettype none
// Table memories, search bounds, divider and blend arithmetic.
module stli_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire stli_pkg::dp_cmd_t                cmd,
  output stli_pkg::dp_status_t                  status,
  input  wire logic [stli_pkg::CountWidth-1:0]  entries_in_use,
  input  wire logic [stli_pkg::IndexWidth-1:0]  entry_index,
  input  wire logic [stli_pkg::ValueWidth-1:0]  entry_radius,
  input  wire logic [stli_pkg::ValueWidth-1:0]  entry_velocity,
  input  wire logic [stli_pkg::ValueWidth-1:0]  entry_density,
  input  wire logic [stli_pkg::ValueWidth-1:0]  query_radius,
  output logic [stli_pkg::ValueWidth-1:0]       out_velocity,
  output logic [stli_pkg::ValueWidth-1:0]       out_density,
  output logic                                  was_clamped,
  output logic [stli_pkg::IndexWidth-1:0]       lower_index
);
  import stli_pkg::*;
  localparam int ProdW = ValueWidth + WeightWidth + 1;

  logic [ValueWidth-1:0] radius_mem   [TableDepth];
  logic [ValueWidth-1:0] velocity_mem [TableDepth];
  logic [ValueWidth-1:0] density_mem  [TableDepth];
  logic [ValueWidth-1:0] rd_radius, rd_velocity, rd_density;

  logic [ValueWidth-1:0] q;
  logic [IndexWidth-1:0] last_idx, lo, hi, mid, rd_addr;
  logic [ValueWidth-1:0] r0, v0, d0, r1, v1, d1;
  logic [WeightWidth:0]  w, w_inv;
  logic [ProdW-1:0]      pv0, pd0, pv1, pd1;
  logic [ProdW:0]        sv, sd;
  logic                  div_done;
  logic [WeightWidth-1:0] quo;
  logic [ValueWidth-1:0] r_off;
  logic                  mid_le;
  logic                  at_first, at_last;

  // Clamp the entry count into the table range
  always_comb begin
    if (entries_in_use < CountWidth'(2))
      last_idx = IndexWidth'(1);
    else if (entries_in_use > CountWidth'(TableDepth))
      last_idx = IndexWidth'(TableDepth - 1);
    else
      last_idx = IndexWidth'(entries_in_use - 1'b1);
  end

  assign mid = IndexWidth'(({1'b0, lo} + {1'b0, hi}) >> 1);

  always_comb begin
    case (cmd.rd_sel)
      RD_LO:   rd_addr = lo;
      RD_LAST: rd_addr = last_idx;
      RD_MID:  rd_addr = mid;
      RD_HI:   rd_addr = hi;
      default: rd_addr = '0;
    endcase
  end

  // Table memories: one write or one read a cycle
  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      radius_mem[entry_index]   <= entry_radius;
      velocity_mem[entry_index] <= entry_velocity;
      density_mem[entry_index]  <= entry_density;
    end
    if (cmd.mem_read) begin
      rd_radius   <= radius_mem[rd_addr];
      rd_velocity <= velocity_mem[rd_addr];
      rd_density  <= density_mem[rd_addr];
    end
  end

  assign r_off  = to_offset(rd_radius);
  assign mid_le = r_off <= q;

  // Search bounds and captured entries
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q  <= to_offset(query_radius);
      lo <= '0;
      hi <= last_idx;
    end
    if (cmd.cap_first) begin
      at_first <= q <= r_off;
      v0 <= rd_velocity;
      d0 <= rd_density;
    end
    if (cmd.cap_last) begin
      at_last <= q >= r_off;
      v1 <= rd_velocity;
      d1 <= rd_density;
    end
    if (cmd.step_search) begin
      if (mid_le) lo <= mid;
      else        hi <= mid;
    end
    if (cmd.cap_lo) begin
      r0 <= r_off;
      v0 <= rd_velocity;
      d0 <= rd_density;
    end
    if (cmd.cap_hi) begin
      r1 <= r_off;
      v1 <= rd_velocity;
      d1 <= rd_density;
    end
  end

  assign status = '{below_first: at_first, above_last: at_last,
                    search_done: (hi - lo) <= IndexWidth'(1), div_done: div_done};

  stli_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (q - r0),
    .den      (r1 - r0),
    .done     (div_done),
    .quotient (quo)
  );

  assign sv = {1'b0, pv0} + {1'b0, pv1};
  assign sd = {1'b0, pd0} + {1'b0, pd1};

  // Weight, then one multiply pair per cycle, then the sum; or a clamped end entry as result
  always_ff @(posedge clk) begin
    if (div_done) begin
      w     <= (r1 > r0 && q >= r0) ? {1'b0, quo} : '0;
      w_inv <= (r1 > r0 && q >= r0) ? (WeightWidth+1)'(17'h10000 - {1'b0, quo})
                                    : (WeightWidth+1)'(17'h10000);
    end
    if (cmd.mul_lo) begin
      pv0 <= ProdW'(to_offset(v0)) * ProdW'(w_inv);
      pd0 <= ProdW'(to_offset(d0)) * ProdW'(w_inv);
    end
    if (cmd.mul_hi) begin
      pv1 <= ProdW'(to_offset(v1)) * ProdW'(w);
      pd1 <= ProdW'(to_offset(d1)) * ProdW'(w);
    end
    if (cmd.sum_out) begin
      out_velocity <= to_offset(sv[WeightWidth +: ValueWidth]);
      out_density  <= to_offset(sd[WeightWidth +: ValueWidth]);
      was_clamped  <= 1'b0;
      lower_index  <= lo;
    end
    if (cmd.set_clamp_first) begin
      out_velocity <= v0;
      out_density  <= d0;
      was_clamped  <= 1'b1;
      lower_index  <= '0;
    end
    if (cmd.set_clamp_last) begin
      out_velocity <= v1;
      out_density  <= d1;
      was_clamped  <= 1'b1;
      lower_index  <= last_idx;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/stli_ctrl.sv =====
`default_nettype none
// Sequencer: table writes, end checks, binary search, divide, blend, result handoff.
module stli_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_mode,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output stli_pkg::dp_cmd_t          cmd,
  input  wire stli_pkg::dp_status_t  status
);
  import stli_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_FIRST, S_RD_LAST, S_CHK, S_OUT, S_MID_RD, S_MID_CMP,
    S_LO_RD, S_HI_RD, S_HI_CAP, S_DIV_GO, S_DIV, S_MUL_LO, S_MUL_HI, S_SUM
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;
  logic   clamp_hit;
  logic   result_load;

  // Input waits for the sequencer only; a new result waits for the output register
  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign clamp_hit   = status.below_first || status.above_last;
  assign result_load = out_free && ((state == S_OUT && clamp_hit) || state == S_SUM);

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_LO;
    case (state)
      S_IDLE: begin
        cmd.mem_write  = accept && !in_mode;
        cmd.load_query = accept && in_mode;
      end
      S_RD_FIRST: begin cmd.mem_read = 1'b1; cmd.rd_sel = RD_LO; end
      S_RD_LAST: begin
        cmd.mem_read = 1'b1; cmd.rd_sel = RD_LAST; cmd.cap_first = 1'b1;
      end
      S_CHK: cmd.cap_last = 1'b1;
      // Clamp decisions
      S_OUT: begin
        cmd.set_clamp_first = out_free && status.below_first;
        cmd.set_clamp_last  = out_free && !status.below_first && status.above_last;
      end
      S_MID_RD: begin cmd.mem_read = 1'b1; cmd.rd_sel = RD_MID; end
      S_MID_CMP: cmd.step_search = 1'b1;
      S_LO_RD: begin cmd.mem_read = 1'b1; cmd.rd_sel = RD_LO; end
      S_HI_RD: begin
        cmd.mem_read = 1'b1; cmd.rd_sel = RD_HI; cmd.cap_lo = 1'b1;
      end
      S_HI_CAP: cmd.cap_hi = 1'b1;
      S_DIV_GO: cmd.div_start = 1'b1;
      S_MUL_LO: cmd.mul_lo = 1'b1;
      S_MUL_HI: cmd.mul_hi = 1'b1;
      S_SUM: cmd.sum_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (result_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE:     if (accept && in_mode) state <= S_RD_FIRST;
        S_RD_FIRST: state <= S_RD_LAST;
        S_RD_LAST:  state <= S_CHK;
        S_CHK:      state <= S_OUT;
        S_OUT: begin
          if (clamp_hit) begin
            if (out_free) state <= S_IDLE;
          end else if (status.search_done) begin
            state <= S_LO_RD;
          end else begin
            state <= S_MID_RD;
          end
        end
        S_MID_RD:  state <= S_MID_CMP;
        S_MID_CMP: state <= status.search_done ? S_LO_RD : S_MID_RD;
        S_LO_RD:   state <= S_HI_RD;
        S_HI_RD:   state <= S_HI_CAP;
        S_HI_CAP:  state <= S_DIV_GO;
        S_DIV_GO:  state <= S_DIV;
        S_DIV:     if (status.div_done) state <= S_MUL_LO;
        S_MUL_LO:  state <= S_MUL_HI;
        S_MUL_HI:  state <= S_SUM;
        S_SUM:     if (out_free) state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sorted_table_linear_interpolator_top.sv =====
`default_nettype none
// Sorted-table linear interpolator. Entries (radius, velocity, density, all
// signed Q16.16) are loaded one per write transfer and must be sorted by
// radius; entries_in_use sets the live count. A query clamps to an end entry
// at or beyond the table ends, otherwise it binary-searches the bracketing pair
// and blends with a truncated Q0.16 weight. A write is stored as it is
// accepted. A clamped query returns after the end reads and the clamp check;
// otherwise the sequencer runs the search steps (a middle read and a compare
// each), then the bracket reads and captures plus the divider launch, a
// 48-step bit-serial divider with its done cycle, and the blend steps: low
// multiply, high multiply, sum. One query is in flight at a time; the next
// item is taken the cycle after the result is loaded into the output
// register, and a result that is still not transferred holds the next query
// just before its own result.
module sorted_table_linear_interpolator_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [stli_pkg::CountWidth-1:0] cfg_wdata,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // tuser: mode
  input  wire logic                            s_tuser,
  // tdata: entry_index[11:0], entry_radius[43:12], entry_velocity[75:44],
  //        entry_density[107:76], query_radius[139:108], zero pad [143:140]
  input  wire logic [143:0]                    s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // tdata: out_velocity[31:0], out_density[63:32], was_clamped[64],
  //        lower_index[76:65], zero pad [79:77]
  output logic [79:0]                          m_tdata
);
  import stli_pkg::*;

  dp_cmd_t               cmd;
  dp_status_t            status;
  logic [CountWidth-1:0] entries_in_use;
  logic [ValueWidth-1:0] out_velocity, out_density;
  logic                  was_clamped;
  logic [IndexWidth-1:0] lower_index;

  // Entry count register
  always_ff @(posedge clk) begin
    if (rst) entries_in_use <= CountWidth'(2);
    else if (cfg_we) entries_in_use <= cfg_wdata;
  end

  stli_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (s_tvalid), .in_mode (s_tuser), .in_ready (s_tready),
    .out_valid (m_tvalid), .out_ready (m_tready),
    .cmd, .status
  );

  stli_datapath u_dp (
    .clk, .rst, .cmd, .status, .entries_in_use,
    .entry_index    (s_tdata[11:0]),
    .entry_radius   (s_tdata[43:12]),
    .entry_velocity (s_tdata[75:44]),
    .entry_density  (s_tdata[107:76]),
    .query_radius   (s_tdata[139:108]),
    .out_velocity, .out_density, .was_clamped, .lower_index
  );

  assign m_tdata = {3'b000, lower_index, was_clamped, out_density, out_velocity};

`ifndef ASSERT_OFF
  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped while stalled");
  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed while stalled");
  // Clamped results report a table end
  a_clamp_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && was_clamped && lower_index != '0) |->
      (lower_index == entries_in_use - 1'b1 || entries_in_use < 13'd2 ||
       entries_in_use > 13'd4096)) else $error("clamped index not an end");
`endif
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;
  import stli_pkg::*;

  typedef struct packed {
    logic [11:0] lower;
    logic        clamped;
    logic [31:0] density;
    logic [31:0] velocity;
  } lookup_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [12:0]  cfg_wdata;
  logic         s_tvalid;
  wire          s_tready;
  logic         s_tuser;
  logic [143:0] s_tdata;
  wire          m_tvalid;
  logic         m_tready;
  wire  [79:0]  m_tdata;

  sorted_table_linear_interpolator_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Shadow copy of the table and count
  logic [31:0] radius_tbl [0:TableDepth-1];
  logic [31:0] vel_tbl [0:TableDepth-1];
  logic [31:0] dens_tbl [0:TableDepth-1];
  bit          written [0:TableDepth-1];
  int unsigned live_count;
  lookup_t     pending_lookups[$];
  int          errors;
  int          cycles;
  int          hold_off;
  bit          stall_en;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] offs(input logic [31:0] v);
    return {~v[31], v[30:0]};
  endfunction

  // Linear blend with Q0.16 weight, floored
  function automatic logic [31:0] mix(input logic [31:0] a0, input logic [31:0] a1,
                                      input logic [63:0] w);
    logic [63:0] s;
    s = {32'd0, offs(a0)} * (64'd65536 - w) + {32'd0, offs(a1)} * w;
    return offs(s[47:16]);
  endfunction

  function automatic lookup_t interpolate(input logic [31:0] qr);
    lookup_t res;
    logic [31:0] q, r0, r1;
    int unsigned n, lo, hi, mid;
    logic [63:0] w;
    n = live_count < 2 ? 2 : (live_count > TableDepth ? TableDepth : live_count);
    q = offs(qr);
    if (q <= offs(radius_tbl[0])) begin
      res = '{velocity: vel_tbl[0], density: dens_tbl[0], clamped: 1'b1, lower: 12'd0};
      return res;
    end
    if (q >= offs(radius_tbl[n-1])) begin
      res = '{velocity: vel_tbl[n-1], density: dens_tbl[n-1], clamped: 1'b1,
              lower: 12'(n-1)};
      return res;
    end
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (offs(radius_tbl[mid]) <= q) lo = mid;
      else hi = mid;
    end
    r0 = offs(radius_tbl[lo]);
    r1 = offs(radius_tbl[hi]);
    w = 0;
    if (r1 > r0 && q >= r0) begin
      w = ({32'd0, q - r0} << 16) / {32'd0, r1 - r0};
      if (w > 65535) w = 65535;
    end
    res.velocity = mix(vel_tbl[lo], vel_tbl[hi], w);
    res.density = mix(dens_tbl[lo], dens_tbl[hi], w);
    res.clamped = 1'b0;
    res.lower = 12'(lo);
    return res;
  endfunction

  // Receiver: random stall pattern plus forced long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // Check each result transfer
  always @(posedge clk) begin
    lookup_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[76:0];
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_lookups.pop_front();
        if (got.velocity !== exp_r.velocity)
          $display("%0t: velocity exp %h got %h", $time, exp_r.velocity, got.velocity);
        if (got.density !== exp_r.density)
          $display("%0t: density exp %h got %h", $time, exp_r.density, got.density);
        if (got.clamped !== exp_r.clamped)
          $display("%0t: clamped exp %b got %b", $time, exp_r.clamped, got.clamped);
        if (got.lower !== exp_r.lower)
          $display("%0t: lower_index exp %0d got %0d", $time, exp_r.lower, got.lower);
        if (got !== exp_r) errors++;
      end
    end
  end

  // Burst state of the sender
  int burst_left;

  // Send one item and update the prediction on acceptance
  task automatic send_item(input bit is_query, input logic [11:0] idx,
                           input logic [31:0] r, input logic [31:0] v,
                           input logic [31:0] d, input logic [31:0] q);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= is_query;
    s_tdata <= {4'd0, q, d, v, r, idx};
    do @(posedge clk); while (!s_tready);
    if (is_query) pending_lookups = {pending_lookups, interpolate(q)};
    else begin
      radius_tbl[idx] = r;
      vel_tbl[idx] = v;
      dens_tbl[idx] = d;
    end
  endtask

  task automatic write_entry(input int idx, input logic [31:0] r);
    send_item(1'b0, idx[11:0], r, $urandom, $urandom, $urandom);
  endtask

  task automatic query(input logic [31:0] q);
    send_item(1'b1, 12'($urandom), $urandom, $urandom, $urandom, q);
  endtask

  // Wait until every expected result arrived, then the block is idle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_count(input int n);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    live_count = n;
  endtask

  // Sorted table of n entries with a given radius step pattern
  task automatic build_table(input int n, input int base, input int spread, input bit dups);
    int r;
    r = base;
    for (int i = 0; i < n; i++) begin
      write_entry(i, r);
      if (!(dups && $urandom_range(0, 3) == 0)) r = r + $urandom_range(1, spread);
    end
  endtask

  // Radius of entry i in the sparse full-depth table
  function automatic int sparse_radius(input int i);
    return -1000000000 + i * 500000;
  endfunction

  // Write the entries that a search for q visits, then send the query
  task automatic query_sparse(input int n, input logic [31:0] q);
    int lo, hi, mid;
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (!written[mid]) begin
        write_entry(mid, sparse_radius(mid));
        written[mid] = 1'b1;
      end
      if (sparse_radius(mid) <= $signed(q)) lo = mid;
      else hi = mid;
    end
    query(q);
  endtask

  // Extremes: full signed range, clamps, equal radii, edge values
  task automatic test_directed();
    set_count(2);
    send_item(1'b0, 12'd0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    send_item(1'b0, 12'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    query(32'h8000_0000);
    query(32'h7fff_ffff);
    query(32'h0);
    query(32'h8000_0001);
    query(32'h7fff_fffe);
    send_item(1'b0, 12'd1, 32'h8000_0000, 32'hffff_ffff, 32'h1, 32'h0);
    query(32'h0);
    send_item(1'b0, 12'd1, 32'h8000_0001, 32'hffff_ffff, 32'h1, 32'h0);
    query(32'h8000_0000);
    send_item(1'b0, 12'd4095, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(1'b1, 12'hfff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h1234_5678);
    drain();
    // Count register below the minimum acts as two
    set_count(0);
    query(32'h4000_0000);
    drain();
    set_count(1);
    query(32'hc000_0000);
    drain();
  endtask

  // Full-depth count on a sparsely written sorted table
  task automatic test_full_table();
    int lo_r, hi_r;
    set_count(TableDepth);
    foreach (written[i]) written[i] = 1'b0;
    write_entry(0, sparse_radius(0));
    written[0] = 1'b1;
    write_entry(TableDepth - 1, sparse_radius(TableDepth - 1));
    written[TableDepth-1] = 1'b1;
    lo_r = sparse_radius(0);
    hi_r = sparse_radius(TableDepth - 1);
    for (int i = 0; i < 40; i++)
      query_sparse(TableDepth, lo_r + 1 + $urandom_range(0, hi_r - lo_r - 2));
    query_sparse(TableDepth, $urandom);
    query(lo_r);
    query(hi_r);
    query_sparse(TableDepth, sparse_radius(2047));
    drain();
    // Count beyond depth acts as depth
    set_count(8191);
    query(32'h7fff_ffff);
    query_sparse(TableDepth, sparse_radius(100) + 1);
    drain();
  endtask

  // Random phases: small tables, mostly in-range queries, some noise
  task automatic test_random();
    int n, base, spread, lo_r, hi_r;
    for (int ph = 0; ph < 17; ph++) begin
      n = $urandom_range(2, 24);
      set_count(n);
      spread = $urandom_range(0, 1) ? $urandom_range(1, 50) : $urandom_range(1, 10000000);
      base = $urandom;
      if (base > 0 && base > 32'sh7fff_ffff - n * spread) base = -base;
      build_table(n, base, spread, $urandom_range(0, 1));
      lo_r = radius_tbl[0];
      hi_r = radius_tbl[n-1];
      for (int k = 0; k < 30; k++) begin
        case ($urandom_range(0, 9))
          0: query($urandom);
          1: query(radius_tbl[$urandom_range(0, n-1)]);
          2: write_entry($urandom_range(0, n-1), radius_tbl[$urandom_range(0, n-1)]);
          default: query(lo_r + $urandom_range(0, hi_r - lo_r));
        endcase
      end
      drain();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering queries
  task automatic test_backpressure();
    set_count(8);
    build_table(8, -5000, 3000, 1'b0);
    hold_off = 400;
    for (int k = 0; k < 20; k++) query(-6000 + $urandom_range(0, 30000));
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    errors = 0;
    hold_off = 0;
    stall_en = 1'b0;
    burst_left = 0;
    live_count = 2;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    stall_en = 1'b1;
    test_backpressure();
    test_random();
    stall_en = 1'b0;
    test_random();
    test_full_table();
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sorted_table_linear_interpolator_top.f =====
hw/rtl/stli_pkg.sv
hw/rtl/stli_divider.sv
hw/rtl/stli_datapath.sv
hw/rtl/stli_ctrl.sv
hw/rtl/sorted_table_linear_interpolator_top.sv
bench/tb_top.sv
